@@ sv/bdpm_pkg.sv @@
// Shared types, constants and the control store for the balance and distance PID mixer.
// Used by every module of the block; depends on nothing else.

package bdpm_pkg;

	// Default width of the signed encoder counts.
	localparam int COUNT_WIDTH_DEF = 12;

	// Fixed field and state widths.
	localparam int GAIN_W  = 24;
	localparam int SPEED_W = 9;
	localparam int TURN_W  = 8;
	localparam int ANGLE_W = 16;
	localparam int DUTY_W  = 8;
	localparam int TI_W    = 26;
	localparam int TT_W    = 24;
	localparam int DRV_W   = 40;
	localparam int QUOT_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Shared multiplier: 24-bit signed operand times a 25-bit signed (zero-extended gain).
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Limits, all with 16 fraction bits.
	localparam longint TILT_LIMIT   = 64'sd32768000;
	localparam longint TRAVEL_LIMIT = 64'sd6553600;
	localparam longint DRIVE_MAX    = 64'sd549755813887;
	localparam longint DRIVE_MIN    = -64'sd549755813888;

	// Division of the distance drive by a constant, a few quotient bits per cycle.
	localparam int DRIVE_DIVISOR = 300;
	localparam int REM_W         = 9;
	localparam int DIV_BITS      = 4;
	localparam int DIV_STEPS     = DRV_W / DIV_BITS;

	// Right wheel scale 13/10: multiply by 13, then divide the integer part by 10.
	localparam int RIGHT_NUM  = 13;
	localparam int RECIP10    = 6554;
	localparam int RIGHT_SAT  = 2560;
	localparam int DUTY_MAX   = 255;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_KP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_KD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_KI  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_KP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_KI = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TURN        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STOPPED     = 3'd7;

	// Reset values of the registers.
	localparam logic [GAIN_W-1:0] BALANCE_KP_RST  = 24'd5242880;
	localparam logic [GAIN_W-1:0] BALANCE_KD_RST  = 24'd655;
	localparam logic [GAIN_W-1:0] BALANCE_KI_RST  = 24'd294912;
	localparam logic [GAIN_W-1:0] DISTANCE_KP_RST = 24'd1310720;
	localparam logic [GAIN_W-1:0] DISTANCE_KI_RST = 24'd262144;

	typedef struct packed {
		logic [GAIN_W-1:0]         balance_kp;
		logic [GAIN_W-1:0]         balance_kd;
		logic [GAIN_W-1:0]         balance_ki;
		logic [GAIN_W-1:0]         distance_kp;
		logic [GAIN_W-1:0]         distance_ki;
		logic signed [SPEED_W-1:0] speed_demand;
		logic signed [TURN_W-1:0]  turn_demand;
		logic                      stopped;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0] right_duty;
		logic [DUTY_W-1:0] left_duty;
		logic              right_forward;
		logic              left_forward;
	} result_t;

	typedef struct packed {
		logic func;
		logic stopped;
		logic div_busy;
		logic out_blocked;
	} seq_flags_t;

	// Multiplier operand selects.
	localparam logic [2:0] MS_NONE    = 3'd0;
	localparam logic [2:0] MS_ERR_KI  = 3'd1;
	localparam logic [2:0] MS_ERR_KP  = 3'd2;
	localparam logic [2:0] MS_RATE_KD = 3'd3;
	localparam logic [2:0] MS_SUM_DKP = 3'd4;
	localparam logic [2:0] MS_TT_DKI  = 3'd5;

	// Accumulator operations.
	localparam logic [3:0] AO_HOLD        = 4'd0;
	localparam logic [3:0] AO_TI_PLUS_P8  = 4'd1;
	localparam logic [3:0] AO_LOAD_P8     = 4'd2;
	localparam logic [3:0] AO_ADD_P8      = 4'd3;
	localparam logic [3:0] AO_ADD_TI      = 4'd4;
	localparam logic [3:0] AO_ADD_OFS     = 4'd5;
	localparam logic [3:0] AO_TT_PLUS_SUM = 4'd6;
	localparam logic [3:0] AO_LOAD_P15    = 4'd7;
	localparam logic [3:0] AO_ADD_P       = 4'd8;

	// Register writes.
	localparam logic [3:0] RO_NONE   = 4'd0;
	localparam logic [3:0] RO_TI     = 4'd1;
	localparam logic [3:0] RO_TT     = 4'd2;
	localparam logic [3:0] RO_WD     = 4'd3;
	localparam logic [3:0] RO_DRV    = 4'd4;
	localparam logic [3:0] RO_QUOT   = 4'd5;
	localparam logic [3:0] RO_WHEEL  = 4'd6;
	localparam logic [3:0] RO_MAG    = 4'd7;
	localparam logic [3:0] RO_SCALE1 = 4'd8;
	localparam logic [3:0] RO_SCALE2 = 4'd9;
	localparam logic [3:0] RO_ZERO   = 4'd10;

	// Jump conditions.
	localparam logic [2:0] JC_NEXT     = 3'd0;
	localparam logic [2:0] JC_ALWAYS   = 3'd1;
	localparam logic [2:0] JC_FUNC     = 3'd2;
	localparam logic [2:0] JC_STOPPED  = 3'd3;
	localparam logic [2:0] JC_DIV_BUSY = 3'd4;

	localparam int PC_W = 5;

	typedef struct packed {
		logic [2:0]      mul_sel;
		logic [3:0]      acc_op;
		logic [3:0]      reg_op;
		logic            div_start;
		logic            out_load;
		logic [2:0]      jump_cond;
		logic [PC_W-1:0] target;
		logic            done;
	} ucode_t;

	localparam ucode_t UCODE_NOP = '0;

	// Program addresses.
	localparam logic [PC_W-1:0] ST_DISPATCH = 5'd0;
	localparam logic [PC_W-1:0] ST_STOPCHK  = 5'd1;
	localparam logic [PC_W-1:0] ST_A0       = 5'd2;
	localparam logic [PC_W-1:0] ST_A1       = 5'd3;
	localparam logic [PC_W-1:0] ST_A2       = 5'd4;
	localparam logic [PC_W-1:0] ST_A3       = 5'd5;
	localparam logic [PC_W-1:0] ST_A4       = 5'd6;
	localparam logic [PC_W-1:0] ST_A5       = 5'd7;
	localparam logic [PC_W-1:0] ST_A6       = 5'd8;
	localparam logic [PC_W-1:0] ST_A7       = 5'd9;
	localparam logic [PC_W-1:0] ST_A8       = 5'd10;
	localparam logic [PC_W-1:0] ST_A9       = 5'd11;
	localparam logic [PC_W-1:0] ST_ZERO     = 5'd12;
	localparam logic [PC_W-1:0] ST_OUT      = 5'd13;
	localparam logic [PC_W-1:0] ST_E0       = 5'd14;
	localparam logic [PC_W-1:0] ST_E1       = 5'd15;
	localparam logic [PC_W-1:0] ST_E2       = 5'd16;
	localparam logic [PC_W-1:0] ST_E3       = 5'd17;
	localparam logic [PC_W-1:0] ST_E4       = 5'd18;
	localparam logic [PC_W-1:0] ST_E5       = 5'd19;
	localparam logic [PC_W-1:0] ST_E6       = 5'd20;
	localparam logic [PC_W-1:0] ST_E7       = 5'd21;

	// Control store. A product issued in one step is available to the next step.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = UCODE_NOP;
		unique case (pc)
			ST_DISPATCH: begin
				w.jump_cond = JC_FUNC;
				w.target    = ST_E0;
			end
			ST_STOPCHK: begin
				w.jump_cond = JC_STOPPED;
				w.target    = ST_ZERO;
			end
			ST_A0: w.mul_sel = MS_ERR_KI;
			ST_A1: begin
				w.mul_sel = MS_ERR_KP;
				w.acc_op  = AO_TI_PLUS_P8;
			end
			ST_A2: begin
				w.mul_sel = MS_RATE_KD;
				w.reg_op  = RO_TI;
				w.acc_op  = AO_LOAD_P8;
			end
			ST_A3: w.acc_op = AO_ADD_P8;
			ST_A4: w.acc_op = AO_ADD_TI;
			ST_A5: w.acc_op = AO_ADD_OFS;
			ST_A6: w.reg_op = RO_WHEEL;
			ST_A7: w.reg_op = RO_MAG;
			ST_A8: w.reg_op = RO_SCALE1;
			ST_A9: begin
				w.reg_op    = RO_SCALE2;
				w.jump_cond = JC_ALWAYS;
				w.target    = ST_OUT;
			end
			ST_ZERO: w.reg_op = RO_ZERO;
			ST_OUT: begin
				w.out_load = 1'b1;
				w.done     = 1'b1;
			end
			ST_E0: begin
				w.mul_sel = MS_SUM_DKP;
				w.acc_op  = AO_TT_PLUS_SUM;
				w.reg_op  = RO_WD;
			end
			ST_E1: begin
				w.reg_op = RO_TT;
				w.acc_op = AO_LOAD_P15;
			end
			ST_E2: w.mul_sel = MS_TT_DKI;
			ST_E3: w.acc_op = AO_ADD_P;
			ST_E4: w.reg_op = RO_DRV;
			ST_E5: w.div_start = 1'b1;
			ST_E6: begin
				w.jump_cond = JC_DIV_BUSY;
				w.target    = ST_E6;
			end
			ST_E7: begin
				w.reg_op = RO_QUOT;
				w.done   = 1'b1;
			end
			default: w.done = 1'b1;
		endcase
		return w;
	endfunction

endpackage

@@ sv/bdpm_div300.sv @@
// Sequential divider of the signed distance drive by 300, truncating toward zero.
// Uses bdpm_pkg for widths and the divisor; several quotient bits per cycle.

module bdpm_div300 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [bdpm_pkg::DRV_W-1:0] dividend,
	output logic                              busy,
	output logic signed [bdpm_pkg::QUOT_W-1:0] quotient
);

	localparam int DRV_W    = bdpm_pkg::DRV_W;
	localparam int QUOT_W   = bdpm_pkg::QUOT_W;
	localparam int REM_W    = bdpm_pkg::REM_W;
	localparam int DIV_BITS = bdpm_pkg::DIV_BITS;
	localparam int STEPS    = bdpm_pkg::DIV_STEPS;
	localparam int CNT_W    = $clog2(STEPS + 1);
	localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(bdpm_pkg::DRIVE_DIVISOR);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DRV_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;

	logic [REM_W-1:0]    rem_next;
	logic [DIV_BITS-1:0] qbits;
	logic [DRV_W-1:0]    mag;

	assign mag = dividend[DRV_W-1] ? DRV_W'(-dividend) : DRV_W'(dividend);

	// Long division: dividend bits leave at the top, quotient bits enter at the bottom.
	always_comb begin
		logic [REM_W:0]   t;
		logic [REM_W-1:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, num_q[DRV_W-1-i]};
			if (t >= DIVISOR) begin
				t = t - DIVISOR;
				qbits[DIV_BITS-1-i] = 1'b1;
			end
			r = t[REM_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DRV_W-1];
			num_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DRV_W-DIV_BITS-1:0], qbits};
			rem_q <= rem_next;
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? -$signed(num_q[QUOT_W-1:0]) : $signed(num_q[QUOT_W-1:0]);

endmodule

@@ sv/bdpm_datapath.sv @@
// Datapath of the mixer: input latch, shared multiplier, accumulator, controller state
// and the duty stage. Driven by control words from the sequencer; uses bdpm_pkg, bdpm_div300.

module bdpm_datapath #(
	parameter int COUNT_WIDTH = bdpm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_load,
	input  logic                                func,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_angle,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_rate,
	input  logic signed [COUNT_WIDTH-1:0]       right_count,
	input  logic signed [COUNT_WIDTH-1:0]       left_count,
	input  bdpm_pkg::cfg_t                      cfg,
	input  bdpm_pkg::ucode_t                    cw,
	output logic                                func_held,
	output logic                                div_busy,
	output bdpm_pkg::result_t                   res
);

	localparam int ANGLE_W = bdpm_pkg::ANGLE_W;
	localparam int ERR_W   = ANGLE_W + 1;
	localparam int SUM_W   = COUNT_WIDTH + 1;
	localparam int DT_W    = COUNT_WIDTH + 2;
	localparam int ACC_W   = COUNT_WIDTH + 42;
	localparam int MUL_A_W = bdpm_pkg::MUL_A_W;
	localparam int MUL_B_W = bdpm_pkg::MUL_B_W;
	localparam int MUL_P_W = bdpm_pkg::MUL_P_W;
	localparam int TI_W    = bdpm_pkg::TI_W;
	localparam int TT_W    = bdpm_pkg::TT_W;
	localparam int DRV_W   = bdpm_pkg::DRV_W;
	localparam int QUOT_W  = bdpm_pkg::QUOT_W;
	localparam int DUTY_W  = bdpm_pkg::DUTY_W;
	localparam int R13_W   = DRV_W + 4;
	localparam int RX_W    = R13_W - 16;
	localparam int X_W     = 12;
	localparam int RP_W    = 25;

	localparam logic signed [ACC_W-1:0] TILT_HI  = ACC_W'(bdpm_pkg::TILT_LIMIT);
	localparam logic signed [ACC_W-1:0] TILT_LO  = ACC_W'(-bdpm_pkg::TILT_LIMIT);
	localparam logic signed [ACC_W-1:0] TRAV_HI  = ACC_W'(bdpm_pkg::TRAVEL_LIMIT);
	localparam logic signed [ACC_W-1:0] TRAV_LO  = ACC_W'(-bdpm_pkg::TRAVEL_LIMIT);
	localparam logic signed [ACC_W-1:0] DRIVE_HI = ACC_W'(bdpm_pkg::DRIVE_MAX);
	localparam logic signed [ACC_W-1:0] DRIVE_LO = ACC_W'(bdpm_pkg::DRIVE_MIN);
	localparam logic [DUTY_W-1:0]       DUTY_MAX = DUTY_W'(bdpm_pkg::DUTY_MAX);

	// Latched input item.
	logic                        func_q;
	logic signed [ANGLE_W-1:0]   angle_q;
	logic signed [ANGLE_W-1:0]   rate_q;
	logic signed [COUNT_WIDTH-1:0] rc_q;
	logic signed [COUNT_WIDTH-1:0] lc_q;

	// Working registers.
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DRV_W-1:0]   drv_q;
	logic signed [DRV_W-1:0]   right_q;
	logic signed [DRV_W-1:0]   left_q;
	logic [DRV_W-1:0]          mag_r_q;
	logic [DRV_W-1:0]          mag_l_q;
	logic                      rsat_q;
	logic [X_W-1:0]            x_q;
	logic [DUTY_W-1:0]         rduty_q;
	logic [DUTY_W-1:0]         lduty_q;
	logic                      rfwd_q;
	logic                      lfwd_q;

	// Controller state.
	logic signed [TI_W-1:0]    ti_q;
	logic signed [TT_W-1:0]    tt_q;
	logic signed [SUM_W-1:0]   wd_q;
	logic signed [QUOT_W-1:0]  quot_q;

	logic signed [ERR_W-1:0]   err;
	logic signed [SUM_W-1:0]   sum_rl;
	logic signed [SUM_W-1:0]   dif_rl;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   prod_x;
	logic signed [ACC_W-1:0]   p8;
	logic signed [ACC_W-1:0]   p15;
	logic signed [ACC_W-1:0]   ofs;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [ACC_W-1:0]   ti_clamp;
	logic signed [ACC_W-1:0]   tt_clamp;
	logic signed [ACC_W-1:0]   drv_sh;
	logic signed [ACC_W-1:0]   drv_sat;
	logic signed [DT_W-1:0]    dt;
	logic signed [DRV_W-1:0]   dt_sh;
	logic [R13_W-1:0]          r13;
	logic [RX_W-1:0]           rx;
	logic [DRV_W-16-1:0]       lx;
	logic [RP_W-1:0]           rp;
	logic signed [QUOT_W-1:0]  div_quot;

	assign err    = -ERR_W'(angle_q);
	assign sum_rl = SUM_W'(rc_q) + SUM_W'(lc_q);
	assign dif_rl = SUM_W'(rc_q) - SUM_W'(lc_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cw.mul_sel)
			bdpm_pkg::MS_ERR_KI: begin
				mul_a = MUL_A_W'(err);
				mul_b = $signed({1'b0, cfg.balance_ki});
			end
			bdpm_pkg::MS_ERR_KP: begin
				mul_a = MUL_A_W'(err);
				mul_b = $signed({1'b0, cfg.balance_kp});
			end
			bdpm_pkg::MS_RATE_KD: begin
				mul_a = MUL_A_W'(rate_q);
				mul_b = $signed({1'b0, cfg.balance_kd});
			end
			bdpm_pkg::MS_SUM_DKP: begin
				mul_a = MUL_A_W'(sum_rl);
				mul_b = $signed({1'b0, cfg.distance_kp});
			end
			bdpm_pkg::MS_TT_DKI: begin
				mul_a = MUL_A_W'(tt_q);
				mul_b = $signed({1'b0, cfg.distance_ki});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_x = ACC_W'(prod_q);
	assign p8     = prod_x >>> 8;
	assign p15    = prod_x <<< 15;

	// With no speed demand the distance hold is active; otherwise the speed offset applies.
	assign ofs = ($signed(cfg.speed_demand) == 0) ? -ACC_W'(quot_q)
		: (ACC_W'($signed(cfg.speed_demand)) <<< 16);

	always_comb begin
		acc_next = acc_q;
		unique case (cw.acc_op)
			bdpm_pkg::AO_TI_PLUS_P8:  acc_next = ACC_W'(ti_q) + p8;
			bdpm_pkg::AO_LOAD_P8:     acc_next = p8;
			bdpm_pkg::AO_ADD_P8:      acc_next = acc_q + p8;
			bdpm_pkg::AO_ADD_TI:      acc_next = acc_q + ACC_W'(ti_q);
			bdpm_pkg::AO_ADD_OFS:     acc_next = acc_q + ofs;
			bdpm_pkg::AO_TT_PLUS_SUM: acc_next = ACC_W'(tt_q) + (ACC_W'(sum_rl) <<< 15);
			bdpm_pkg::AO_LOAD_P15:    acc_next = p15;
			bdpm_pkg::AO_ADD_P:       acc_next = acc_q + prod_x;
			default:                  acc_next = acc_q;
		endcase
	end

	assign ti_clamp = (acc_q > TILT_HI) ? TILT_HI : ((acc_q < TILT_LO) ? TILT_LO : acc_q);
	assign tt_clamp = (acc_q > TRAV_HI) ? TRAV_HI : ((acc_q < TRAV_LO) ? TRAV_LO : acc_q);
	assign drv_sh   = acc_q >>> 16;
	assign drv_sat  = (drv_sh > DRIVE_HI) ? DRIVE_HI
		: ((drv_sh < DRIVE_LO) ? DRIVE_LO : drv_sh);

	assign dt    = DT_W'(wd_q) - DT_W'(cfg.turn_demand);
	assign dt_sh = DRV_W'(dt) <<< 16;

	// Right wheel: times 13 by shift and add, then the integer part is divided by 10.
	assign r13 = R13_W'({mag_r_q, 3'b000}) + R13_W'({mag_r_q, 2'b00}) + R13_W'(mag_r_q);
	assign rx  = r13[R13_W-1:16];
	assign lx  = mag_l_q[DRV_W-1:16];
	assign rp  = RP_W'(x_q) * RP_W'(bdpm_pkg::RECIP10);

	bdpm_div300 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cw.div_start),
		.dividend (drv_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (in_load) begin
			func_q  <= func;
			angle_q <= tilt_angle;
			rate_q  <= tilt_rate;
			rc_q    <= right_count;
			lc_q    <= left_count;
		end
		prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
		acc_q  <= acc_next;
		unique case (cw.reg_op)
			bdpm_pkg::RO_DRV: drv_q <= drv_sat[DRV_W-1:0];
			bdpm_pkg::RO_WHEEL: begin
				right_q <= acc_q[DRV_W-1:0] - dt_sh;
				left_q  <= acc_q[DRV_W-1:0] + dt_sh;
			end
			bdpm_pkg::RO_MAG: begin
				mag_r_q <= right_q[DRV_W-1] ? DRV_W'(-right_q) : DRV_W'(right_q);
				mag_l_q <= left_q[DRV_W-1] ? DRV_W'(-left_q) : DRV_W'(left_q);
				rfwd_q  <= !right_q[DRV_W-1];
				lfwd_q  <= !left_q[DRV_W-1];
			end
			bdpm_pkg::RO_SCALE1: begin
				rsat_q  <= (rx >= RX_W'(bdpm_pkg::RIGHT_SAT));
				x_q     <= rx[X_W-1:0];
				lduty_q <= (lx > (DRV_W - 16)'(bdpm_pkg::DUTY_MAX)) ? DUTY_MAX : lx[DUTY_W-1:0];
			end
			bdpm_pkg::RO_SCALE2: rduty_q <= rsat_q ? DUTY_MAX : rp[DUTY_W+15:16];
			bdpm_pkg::RO_ZERO: begin
				rduty_q <= '0;
				lduty_q <= '0;
				rfwd_q  <= 1'b1;
				lfwd_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q   <= '0;
			tt_q   <= '0;
			wd_q   <= '0;
			quot_q <= '0;
		end else begin
			unique case (cw.reg_op)
				bdpm_pkg::RO_TI:   ti_q   <= ti_clamp[TI_W-1:0];
				bdpm_pkg::RO_TT:   tt_q   <= tt_clamp[TT_W-1:0];
				bdpm_pkg::RO_WD:   wd_q   <= dif_rl;
				bdpm_pkg::RO_QUOT: quot_q <= div_quot;
				default: begin
				end
			endcase
		end
	end

	assign func_held         = func_q;
	assign res.right_duty    = rduty_q;
	assign res.left_duty     = lduty_q;
	assign res.right_forward = rfwd_q;
	assign res.left_forward  = lfwd_q;

endmodule

@@ sv/bdpm_sequencer.sv @@
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Uses bdpm_pkg for the control word layout and the program itself.

module bdpm_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bdpm_pkg::seq_flags_t flags,
	output logic                 idle,
	output bdpm_pkg::ucode_t     cw
);

	localparam int PC_W = bdpm_pkg::PC_W;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;

	bdpm_pkg::ucode_t rom;
	logic             stall;
	logic             take;

	assign rom   = bdpm_pkg::ucode_rom(pc_q);
	// The output step waits while the previous result has not been transferred.
	assign stall = rom.out_load && flags.out_blocked;

	always_comb begin
		unique case (rom.jump_cond)
			bdpm_pkg::JC_ALWAYS:   take = 1'b1;
			bdpm_pkg::JC_FUNC:     take = flags.func;
			bdpm_pkg::JC_STOPPED:  take = flags.stopped;
			bdpm_pkg::JC_DIV_BUSY: take = flags.div_busy;
			default:               take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= bdpm_pkg::ST_DISPATCH;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= bdpm_pkg::ST_DISPATCH;
			end
		end else if (!stall) begin
			if (rom.done) begin
				busy_q <= 1'b0;
			end
			pc_q <= take ? rom.target : pc_q + PC_W'(1);
		end
	end

	assign idle = !busy_q;
	assign cw   = (busy_q && !stall) ? rom : bdpm_pkg::UCODE_NOP;

endmodule

@@ sv/balance_and_distance_pid_mixer_unit.sv @@
// Two-wheel balance controller with distance hold: one item at a time through a
// microprogrammed datapath with one shared 24x25 multiplier. An angle item gives one
// result, also when stopped. An encoder item gives no result and spends part of its
// program in the divide-by-300 unit, which delivers four quotient bits a cycle. The input
// is ready again in the cycle after an item's last step; a finished result waits in the
// output register and only the final step of the next angle item waits for it to be taken.
// Configuration writes are taken at any edge with cfg_we.
// Depends on bdpm_pkg, bdpm_sequencer and bdpm_datapath.

module balance_and_distance_pid_mixer_unit #(
	parameter int COUNT_WIDTH = bdpm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bdpm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdpm_pkg::GAIN_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0]   tilt_angle,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0]   tilt_rate,
	input  logic signed [COUNT_WIDTH-1:0]         right_count,
	input  logic signed [COUNT_WIDTH-1:0]         left_count,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bdpm_pkg::DUTY_W-1:0]           right_duty,
	output logic [bdpm_pkg::DUTY_W-1:0]           left_duty,
	output logic                                  right_forward,
	output logic                                  left_forward
);

	bdpm_pkg::cfg_t       cfg_q;
	bdpm_pkg::ucode_t     cw;
	bdpm_pkg::seq_flags_t flags;
	bdpm_pkg::result_t    res;
	bdpm_pkg::result_t    out_q;
	logic                 out_valid_q;
	logic                 idle;
	logic                 in_xfer;
	logic                 func_held;
	logic                 div_busy;

	assign in_xfer = in_valid && idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.balance_kp  <= bdpm_pkg::BALANCE_KP_RST;
			cfg_q.balance_kd  <= bdpm_pkg::BALANCE_KD_RST;
			cfg_q.balance_ki  <= bdpm_pkg::BALANCE_KI_RST;
			cfg_q.distance_kp <= bdpm_pkg::DISTANCE_KP_RST;
			cfg_q.distance_ki <= bdpm_pkg::DISTANCE_KI_RST;
			cfg_q.speed_demand <= '0;
			cfg_q.turn_demand  <= '0;
			cfg_q.stopped      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdpm_pkg::REG_BALANCE_KP:  cfg_q.balance_kp  <= cfg_data;
				bdpm_pkg::REG_BALANCE_KD:  cfg_q.balance_kd  <= cfg_data;
				bdpm_pkg::REG_BALANCE_KI:  cfg_q.balance_ki  <= cfg_data;
				bdpm_pkg::REG_DISTANCE_KP: cfg_q.distance_kp <= cfg_data;
				bdpm_pkg::REG_DISTANCE_KI: cfg_q.distance_ki <= cfg_data;
				bdpm_pkg::REG_SPEED:   cfg_q.speed_demand <= cfg_data[bdpm_pkg::SPEED_W-1:0];
				bdpm_pkg::REG_TURN:    cfg_q.turn_demand  <= cfg_data[bdpm_pkg::TURN_W-1:0];
				bdpm_pkg::REG_STOPPED: cfg_q.stopped      <= cfg_data[0];
			endcase
		end
	end

	assign flags.func        = func_held;
	assign flags.stopped     = cfg_q.stopped;
	assign flags.div_busy    = div_busy;
	assign flags.out_blocked = out_valid_q && !out_ready;

	bdpm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.flags  (flags),
		.idle   (idle),
		.cw     (cw)
	);

	bdpm_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_load     (in_xfer),
		.func        (func),
		.tilt_angle  (tilt_angle),
		.tilt_rate   (tilt_rate),
		.right_count (right_count),
		.left_count  (left_count),
		.cfg         (cfg_q),
		.cw          (cw),
		.func_held   (func_held),
		.div_busy    (div_busy),
		.res         (res)
	);

	// The sequencer only issues the load once the register is free or being emptied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_load) begin
			out_q <= res;
		end
	end

	assign in_ready      = idle;
	assign out_valid     = out_valid_q;
	assign right_duty    = out_q.right_duty;
	assign left_duty     = out_q.left_duty;
	assign right_forward = out_q.right_forward;
	assign left_forward  = out_q.left_forward;

endmodule

@@ sv/bdpm_checker.sv @@
// Port-level checks for the balance and distance PID mixer, bound to the top level.
// Depends on bdpm_pkg for port widths.

module bdpm_assertions #(
	parameter int COUNT_WIDTH = bdpm_pkg::COUNT_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_we,
	input logic [bdpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [bdpm_pkg::GAIN_W-1:0]         cfg_data,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                func,
	input logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_angle,
	input logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_rate,
	input logic signed [COUNT_WIDTH-1:0]       right_count,
	input logic signed [COUNT_WIDTH-1:0]       left_count,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [bdpm_pkg::DUTY_W-1:0]         right_duty,
	input logic [bdpm_pkg::DUTY_W-1:0]         left_duty,
	input logic                                right_forward,
	input logic                                left_forward
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({right_duty, left_duty, right_forward, left_forward}))
		else $error("result changed or dropped before its transfer");

	// Every item occupies the block for at least the dispatch steps.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input ready again too soon after a transfer");

	// A result only appears at the end of an item's program.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while no item was in progress");

endmodule

bind balance_and_distance_pid_mixer_unit bdpm_assertions #(
	.COUNT_WIDTH (COUNT_WIDTH)
) u_bdpm_assertions (.*);

@@ tb/bdpm_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the balance and distance PID mixer: mirrors the controller state,
// predicts the wheel duties of each angle transfer and compares them with the results.
// Depends on bdpm_pkg for the result type, register indexes, reset values and limits.

module bdpm_checker #(
	parameter int COUNT_WIDTH = bdpm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bdpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bdpm_pkg::GAIN_W-1:0]         cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                func,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_angle,
	input  logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_rate,
	input  logic signed [COUNT_WIDTH-1:0]       right_count,
	input  logic signed [COUNT_WIDTH-1:0]       left_count,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [bdpm_pkg::DUTY_W-1:0]         right_duty,
	input  logic [bdpm_pkg::DUTY_W-1:0]         left_duty,
	input  logic                                right_forward,
	input  logic                                left_forward,
	output int                                  failures,
	output int                                  pending
);

	localparam longint ONE = 65536;

	// Mirrored registers.
	logic [bdpm_pkg::GAIN_W-1:0] kp, kd, ki, dkp, dki;
	longint speed, turn;
	logic stop;

	// Mirrored controller state, 16 fraction bits except the wheel difference.
	longint tilt_sum, travel_sum, travel_out, wheel_diff;

	bdpm_pkg::result_t duty_due[$];
	bdpm_pkg::result_t predicted, seen, oldest;
	int reported;

	function automatic longint bound(input longint x, input longint lo, input longint hi);
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	function automatic logic [7:0] duty_mag(input longint x, input longint num,
			input longint den);
		longint m;
		m = ((x < 0) ? -x : x) * num / (den * ONE);
		return (m > bdpm_pkg::DUTY_MAX) ? 8'd255 : m[7:0];
	endfunction

	task automatic run_encoder(input longint r, input longint l);
		longint mean, sum;
		mean = (r + l) * (ONE / 2);
		travel_sum = bound(travel_sum + mean, -bdpm_pkg::TRAVEL_LIMIT, bdpm_pkg::TRAVEL_LIMIT);
		sum = mean * longint'(dkp) + travel_sum * longint'(dki);
		travel_out = bound(sum >>> 16, bdpm_pkg::DRIVE_MIN, bdpm_pkg::DRIVE_MAX);
		wheel_diff = r - l;
	endtask

	task automatic run_angle(input longint tilt, input longint rate,
			output bdpm_pkg::result_t res);
		longint err, p, d, u, common, right, left;
		if (stop) begin
			res.right_duty    = '0;
			res.left_duty     = '0;
			res.right_forward = 1'b1;
			res.left_forward  = 1'b1;
		end else begin
			err = -tilt;
			p = (err * longint'(kp)) >>> 8;
			d = (rate * longint'(kd)) >>> 8;
			tilt_sum = bound(tilt_sum + ((err * longint'(ki)) >>> 8),
				-bdpm_pkg::TILT_LIMIT, bdpm_pkg::TILT_LIMIT);
			u = p + d + tilt_sum;
			// Distance hold only acts while no speed is demanded.
			if (speed == 0)
				u = u - travel_out / bdpm_pkg::DRIVE_DIVISOR;
			common = u + speed * ONE;
			right  = common - (wheel_diff - turn) * ONE;
			left   = common + (wheel_diff - turn) * ONE;
			res.right_duty    = duty_mag(right, 13, 10);
			res.left_duty     = duty_mag(left, 1, 1);
			res.right_forward = (right >= 0);
			res.left_forward  = (left >= 0);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			kp = bdpm_pkg::BALANCE_KP_RST;
			kd = bdpm_pkg::BALANCE_KD_RST;
			ki = bdpm_pkg::BALANCE_KI_RST;
			dkp = bdpm_pkg::DISTANCE_KP_RST;
			dki = bdpm_pkg::DISTANCE_KI_RST;
			speed = 0;
			turn = 0;
			stop = 1'b0;
			tilt_sum = 0;
			travel_sum = 0;
			travel_out = 0;
			wheel_diff = 0;
			duty_due.delete();
			failures = 0;
			reported = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.right_duty    = right_duty;
				seen.left_duty     = left_duty;
				seen.right_forward = right_forward;
				seen.left_forward  = left_forward;
				if (duty_due.size() == 0) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("%0t: result transfer with nothing expected: %p", $realtime, seen);
					end
				end else begin
					oldest = duty_due.pop_front();
					if (seen.right_duty !== oldest.right_duty ||
							seen.left_duty !== oldest.left_duty ||
							seen.right_forward !== oldest.right_forward ||
							seen.left_forward !== oldest.left_forward) begin
						failures++;
						if (reported < 10) begin
							reported++;
							$display("%0t: duty mismatch: expected R %0d fwd %0d L %0d fwd %0d, got R %0d fwd %0d L %0d fwd %0d",
								$realtime, oldest.right_duty, oldest.right_forward,
								oldest.left_duty, oldest.left_forward, seen.right_duty,
								seen.right_forward, seen.left_duty, seen.left_forward);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bdpm_pkg::REG_BALANCE_KP:  kp = cfg_data;
					bdpm_pkg::REG_BALANCE_KD:  kd = cfg_data;
					bdpm_pkg::REG_BALANCE_KI:  ki = cfg_data;
					bdpm_pkg::REG_DISTANCE_KP: dkp = cfg_data;
					bdpm_pkg::REG_DISTANCE_KI: dki = cfg_data;
					bdpm_pkg::REG_SPEED:       speed = $signed(cfg_data[bdpm_pkg::SPEED_W-1:0]);
					bdpm_pkg::REG_TURN:        turn = $signed(cfg_data[bdpm_pkg::TURN_W-1:0]);
					bdpm_pkg::REG_STOPPED:     stop = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				// The func bit is set for an encoder period, which updates state only.
				if (func) begin
					run_encoder(right_count, left_count);
				end else begin
					run_angle(tilt_angle, tilt_rate, predicted);
					duty_due.push_back(predicted);
				end
			end
		end
		pending <= duty_due.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the mixer testbench: clock, reset, register settings and randomized item and
// result traffic; the verdict comes from the failure and pending counts of bdpm_checker.
// Depends on bdpm_pkg, bdpm_checker and balance_and_distance_pid_mixer_unit.

module tb;

	localparam logic FUNC_ANGLE   = 1'b0;
	localparam logic FUNC_ENCODER = 1'b1;
	localparam int   CW = bdpm_pkg::COUNT_WIDTH_DEF;

	logic clk, arst_n;
	logic cfg_we;
	logic [bdpm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bdpm_pkg::GAIN_W-1:0] cfg_data;
	logic in_valid, in_ready, func;
	logic signed [bdpm_pkg::ANGLE_W-1:0] tilt_angle, tilt_rate;
	logic signed [CW-1:0] right_count, left_count;
	logic out_valid, out_ready;
	logic [bdpm_pkg::DUTY_W-1:0] right_duty, left_duty;
	logic right_forward, left_forward;

	int failures, pending;
	int valid_gap_max, ready_gap_max;
	int taken;
	logic [bdpm_pkg::GAIN_W-1:0] setting [8];

	balance_and_distance_pid_mixer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.tilt_angle(tilt_angle), .tilt_rate(tilt_rate),
		.right_count(right_count), .left_count(left_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.right_duty(right_duty), .left_duty(left_duty),
		.right_forward(right_forward), .left_forward(left_forward)
	);

	bdpm_checker duty_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.tilt_angle(tilt_angle), .tilt_rate(tilt_rate),
		.right_count(right_count), .left_count(left_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.right_duty(right_duty), .left_duty(left_duty),
		.right_forward(right_forward), .left_forward(left_forward),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Writes all eight registers on consecutive edges.
	task automatic load_settings();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= setting[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Valid stays high from one item to the next when no gap is drawn.
	task automatic send_item(input logic f, input logic [15:0] ta, input logic [15:0] tr,
			input logic [CW-1:0] rc, input logic [CW-1:0] lc);
		int gap;
		gap = $urandom_range(0, valid_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		tilt_angle  <= ta;
		tilt_rate   <= tr;
		right_count <= rc;
		left_count  <= lc;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic angle_item(input logic [15:0] ta, input logic [15:0] tr);
		send_item(FUNC_ANGLE, ta, tr, CW'($urandom), CW'($urandom));
	endtask

	task automatic encoder_item(input logic [CW-1:0] rc, input logic [CW-1:0] lc);
		send_item(FUNC_ENCODER, 16'($urandom), 16'($urandom), rc, lc);
	endtask

	task automatic random_item();
		logic [15:0] ta, tr;
		logic [CW-1:0] rc, lc;
		ta = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
		tr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
		rc = ($urandom_range(0, 7) == 0) ? CW'($urandom) : CW'($urandom_range(0, 80) - 40);
		lc = ($urandom_range(0, 7) == 0) ? CW'($urandom) : CW'($urandom_range(0, 80) - 40);
		send_item($urandom_range(0, 1) ? FUNC_ENCODER : FUNC_ANGLE, ta, tr, rc, lc);
	endtask

	// Drops valid, lets every expected result arrive, then covers an encoder item
	// that may still be running before the registers change.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [23:0] random_gain();
		return ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 23));
	endfunction

	task automatic pick_settings();
		setting[bdpm_pkg::REG_BALANCE_KP]  = random_gain();
		setting[bdpm_pkg::REG_BALANCE_KD]  = random_gain();
		setting[bdpm_pkg::REG_BALANCE_KI]  = random_gain();
		setting[bdpm_pkg::REG_DISTANCE_KP] = random_gain();
		setting[bdpm_pkg::REG_DISTANCE_KI] = random_gain();
		setting[bdpm_pkg::REG_SPEED]   = $urandom_range(0, 1) ? 24'd0 : 24'($urandom & 9'h1FF);
		setting[bdpm_pkg::REG_TURN]    = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom & 8'hFF);
		setting[bdpm_pkg::REG_STOPPED] = ($urandom_range(0, 4) == 0) ? 24'd1 : 24'd0;
	endtask

	task automatic set_all_gains(input logic [23:0] g);
		setting[bdpm_pkg::REG_BALANCE_KP]  = g;
		setting[bdpm_pkg::REG_BALANCE_KD]  = g;
		setting[bdpm_pkg::REG_BALANCE_KI]  = g;
		setting[bdpm_pkg::REG_DISTANCE_KP] = g;
		setting[bdpm_pkg::REG_DISTANCE_KI] = g;
	endtask

	function automatic int pick_gap_max();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4;
			default: return 15;
		endcase
	endfunction

	// Receiver: random stalls per result, plus two long hold-offs that back the
	// block up into its input while the sender keeps offering items.
	initial begin
		int hold;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 60 || taken == 400)
				hold = 300;
			else
				hold = $urandom_range(0, ready_gap_max);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_ANGLE;
		tilt_angle = '0;
		tilt_rate = '0;
		right_count = '0;
		left_count = '0;
		valid_gap_max = 15;
		ready_gap_max = 15;
		setting[bdpm_pkg::REG_BALANCE_KP]  = bdpm_pkg::BALANCE_KP_RST;
		setting[bdpm_pkg::REG_BALANCE_KD]  = bdpm_pkg::BALANCE_KD_RST;
		setting[bdpm_pkg::REG_BALANCE_KI]  = bdpm_pkg::BALANCE_KI_RST;
		setting[bdpm_pkg::REG_DISTANCE_KP] = bdpm_pkg::DISTANCE_KP_RST;
		setting[bdpm_pkg::REG_DISTANCE_KI] = bdpm_pkg::DISTANCE_KI_RST;
		setting[bdpm_pkg::REG_SPEED]   = '0;
		setting[bdpm_pkg::REG_TURN]    = '0;
		setting[bdpm_pkg::REG_STOPPED] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes, the tilt integral and travel integral
		// clamps, and left/right count differences of both signs.
		angle_item(16'sd0, 16'sd0);
		angle_item(16'sd32767, 16'sd32767);
		angle_item(-16'sd32768, -16'sd32768);
		angle_item(-16'sd32768, 16'sd0);
		angle_item(16'sd32767, -16'sd32768);
		encoder_item(12'sd2047, 12'sd2047);
		angle_item(16'sd100, -16'sd50);
		encoder_item(-12'sd2048, -12'sd2048);
		encoder_item(12'sd2047, -12'sd2048);
		angle_item(16'sd0, 16'sd0);
		encoder_item(-12'sd2048, 12'sd2047);
		angle_item(16'sd256, 16'sd512);
		encoder_item(12'sd5, -12'sd3);
		angle_item(-16'sd256, 16'sd100);
		settle();

		// Stopped: zero duties, integral frozen, encoder items still tracked.
		setting[bdpm_pkg::REG_STOPPED] = 24'd1;
		setting[bdpm_pkg::REG_SPEED] = 24'h1FF;
		load_settings();
		angle_item(16'sd1000, 16'sd1000);
		encoder_item(12'sd100, 12'sd50);
		angle_item(-16'sd1000, 16'sd0);
		settle();

		setting[bdpm_pkg::REG_STOPPED] = 24'd0;
		setting[bdpm_pkg::REG_SPEED] = 24'd150;
		setting[bdpm_pkg::REG_TURN] = 24'($signed(-8'sd100));
		load_settings();
		angle_item(16'sd500, -16'sd500);
		encoder_item(-12'sd20, 12'sd20);
		angle_item(-16'sd500, 16'sd500);
		settle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					set_all_gains(24'hFFFFFF);
					setting[bdpm_pkg::REG_SPEED]   = 24'h0FF;
					setting[bdpm_pkg::REG_TURN]    = 24'h7F;
					setting[bdpm_pkg::REG_STOPPED] = 24'd0;
				end
				1: begin
					set_all_gains(24'd0);
					setting[bdpm_pkg::REG_SPEED]   = 24'h100;
					setting[bdpm_pkg::REG_TURN]    = 24'h80;
					setting[bdpm_pkg::REG_STOPPED] = 24'd0;
				end
				2: begin
					set_all_gains(24'hFFFFFF);
					setting[bdpm_pkg::REG_SPEED]   = 24'd0;
					setting[bdpm_pkg::REG_TURN]    = 24'd0;
					setting[bdpm_pkg::REG_STOPPED] = 24'd0;
				end
				default: pick_settings();
			endcase
			valid_gap_max = pick_gap_max();
			ready_gap_max = pick_gap_max();
			load_settings();
			repeat (75) random_item();
			settle();
		end

		if (failures == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
